/* rtl/core/json_array_object_framer_assert.svh */
// Assertion helpers used by the framer scan RTL.
// Each macro expands to one labeled concurrent assertion, disabled while
// the asynchronous reset is asserted.
`ifndef JSON_ARRAY_OBJECT_FRAMER_ASSERT_SVH
`define JSON_ARRAY_OBJECT_FRAMER_ASSERT_SVH

// Same-cycle implication
`define JAOF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication
`define JAOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

/* rtl/core/jaof_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaof_pkg
// Types and constants shared by the JSON array object framer modules.
// ----------------------------------------------------------------------------
package jaof_pkg;

	// Object buffer size; the length limit never exceeds it
	localparam int unsigned BUFFER_BYTES = 2048;
	localparam logic [11:0] BUFFER_LIMIT = 12'(BUFFER_BYTES);

	localparam logic [10:0] DEPTH_MAX = 11'h7FF;
	localparam logic [9:0]  COUNT_MAX = 10'h3FF;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OBJECT_BYTES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OBJECTS      = 2'd1;

	localparam logic [11:0] MAX_OBJECT_BYTES_RST = 12'd1536;
	localparam logic [9:0]  MAX_OBJECTS_RST      = 10'd250;

	// Structural characters
	localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
	localparam logic [7:0] ASCII_RBRACKET = 8'h5D;
	localparam logic [7:0] ASCII_LBRACE   = 8'h7B;
	localparam logic [7:0] ASCII_RBRACE   = 8'h7D;
	localparam logic [7:0] ASCII_QUOTE    = 8'h22;
	localparam logic [7:0] ASCII_BSLASH   = 8'h5C;

	typedef enum logic [2:0] {
		CH_OTHER,
		CH_LBRACKET,
		CH_RBRACKET,
		CH_LBRACE,
		CH_RBRACE,
		CH_QUOTE,
		CH_BSLASH
	} char_kind_t;

	typedef struct packed {
		logic [11:0] max_object_bytes;
		logic [9:0]  max_objects;
	} cfg_t;

	// Classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       restart;
		char_kind_t kind;
	} scan_item_t;

	// One result transaction
	typedef struct packed {
		logic [7:0]  byte_out;
		logic        keep;
		logic [10:0] position;
		logic        object_end;
		logic        object_good;
		logic        scan_done;
		logic [9:0]  objects_seen;
	} result_t;

endpackage

/* rtl/core/jaof_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaof_fifo
// Small show-ahead register queue; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module jaof_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0] COUNT_FULL = (AW + 1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == COUNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/core/jaof_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaof_front
// Accepts input bytes, tags each with its character class and queues it
// for the scanner.
// ----------------------------------------------------------------------------
module jaof_front #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 restart,
	output logic                 item_valid,
	output jaof_pkg::scan_item_t item,
	input  logic                 item_pop
);
	import jaof_pkg::*;

	scan_item_t in_item;
	logic       q_empty;

	// Character classification
	always_comb begin
		in_item.data    = data_byte;
		in_item.restart = restart;
		unique case (data_byte)
			ASCII_LBRACKET: in_item.kind = CH_LBRACKET;
			ASCII_RBRACKET: in_item.kind = CH_RBRACKET;
			ASCII_LBRACE:   in_item.kind = CH_LBRACE;
			ASCII_RBRACE:   in_item.kind = CH_RBRACE;
			ASCII_QUOTE:    in_item.kind = CH_QUOTE;
			ASCII_BSLASH:   in_item.kind = CH_BSLASH;
			default:        in_item.kind = CH_OTHER;
		endcase
	end

	// Command queue toward the scanner
	jaof_fifo #(
		.WIDTH ($bits(scan_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_item),
		.full   (full),
		.pop    (item_pop),
		.rdata  (item),
		.empty  (q_empty)
	);

	assign item_valid = !q_empty;

endmodule

/* rtl/core/jaof_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaof_scan
// Scan state machine: array entry, object framing, string and escape
// tracking, length limit and object count. One byte per cycle while an item is queued and the result side is ready.
// ----------------------------------------------------------------------------
`include "json_array_object_framer_assert.svh"

module jaof_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jaof_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	input  jaof_pkg::scan_item_t item,
	output logic                 item_pop,
	input  logic                 res_ready,
	output logic                 res_push,
	output jaof_pkg::result_t    res
);
	import jaof_pkg::*;

	logic        seen_array_q, in_object_q, in_string_q, escape_q;
	logic [10:0] brace_depth_q;
	logic [11:0] object_length_q;
	logic        overflowed_q, finished_q;
	logic [9:0]  object_count_q;

	// state after optional restart
	logic        e_seen, e_inobj, e_instr, e_esc, e_ovf, e_fin;
	logic [10:0] e_depth;
	logic [11:0] e_len;
	logic [9:0]  e_count;

	// next state
	logic        n_seen, n_inobj, n_instr, n_esc, n_ovf, n_fin;
	logic [10:0] n_depth;
	logic [11:0] n_len;
	logic [9:0]  n_count;

	logic [11:0] limit;
	logic [10:0] depth_dec;
	logic        step;

	assign step     = item_valid && res_ready;
	assign item_pop = step;
	assign res_push = step;

	// Effective length limit
	assign limit = (cfg.max_object_bytes > BUFFER_LIMIT) ? BUFFER_LIMIT : cfg.max_object_bytes;

	// Restart clears the scan before this byte
	always_comb begin
		e_seen  = item.restart ? 1'b0 : seen_array_q;
		e_inobj = item.restart ? 1'b0 : in_object_q;
		e_instr = item.restart ? 1'b0 : in_string_q;
		e_esc   = item.restart ? 1'b0 : escape_q;
		e_ovf   = item.restart ? 1'b0 : overflowed_q;
		e_fin   = item.restart ? 1'b0 : finished_q;
		e_depth = item.restart ? '0 : brace_depth_q;
		e_len   = item.restart ? '0 : object_length_q;
		e_count = item.restart ? '0 : object_count_q;
	end

	// Byte handling
	always_comb begin
		n_seen    = e_seen;
		n_inobj   = e_inobj;
		n_instr   = e_instr;
		n_esc     = e_esc;
		n_ovf     = e_ovf;
		n_fin     = e_fin;
		n_depth   = e_depth;
		n_len     = e_len;
		n_count   = e_count;
		depth_dec = (e_depth != '0) ? e_depth - 1'b1 : e_depth;

		res.byte_out    = item.data;
		res.keep        = 1'b0;
		res.position    = '0;
		res.object_end  = 1'b0;
		res.object_good = 1'b0;

		if (e_fin) begin
			// scan over, byte ignored
		end else if (!e_seen) begin
			if (item.kind == CH_LBRACKET) begin
				n_seen = 1'b1;
			end
		end else if (!e_inobj) begin
			if (item.kind == CH_LBRACE) begin
				n_inobj      = 1'b1;
				n_instr      = 1'b0;
				n_esc        = 1'b0;
				n_ovf        = 1'b0;
				n_depth      = 11'd1;
				n_len        = 12'd1;
				res.keep     = 1'b1;
			end else if (item.kind == CH_RBRACKET) begin
				n_fin = 1'b1;
			end
		end else begin
			// buffer store or overflow
			if (e_len < limit) begin
				res.keep     = 1'b1;
				res.position = e_len[10:0];
				n_len        = e_len + 1'b1;
			end else begin
				n_ovf = 1'b1;
			end

			// string, escape and brace tracking
			if (e_instr) begin
				if (e_esc) begin
					n_esc = 1'b0;
				end else if (item.kind == CH_BSLASH) begin
					n_esc = 1'b1;
				end else if (item.kind == CH_QUOTE) begin
					n_instr = 1'b0;
				end
			end else if (item.kind == CH_QUOTE) begin
				n_instr = 1'b1;
			end else if (item.kind == CH_LBRACE) begin
				if (e_depth != DEPTH_MAX) begin
					n_depth = e_depth + 1'b1;
				end
			end else if (item.kind == CH_RBRACE) begin
				n_depth = depth_dec;
				if (depth_dec == '0) begin
					n_inobj         = 1'b0;
					res.object_end  = 1'b1;
					res.object_good = !n_ovf;
					n_len           = '0;
					if (e_count != COUNT_MAX) begin
						n_count = e_count + 1'b1;
					end
					if (n_count >= cfg.max_objects) begin
						n_fin = 1'b1;
					end
				end
			end
		end

		res.scan_done    = n_fin;
		res.objects_seen = n_count;
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_array_q    <= 1'b0;
			in_object_q     <= 1'b0;
			in_string_q     <= 1'b0;
			escape_q        <= 1'b0;
			brace_depth_q   <= '0;
			object_length_q <= '0;
			overflowed_q    <= 1'b0;
			finished_q      <= 1'b0;
			object_count_q  <= '0;
		end else if (step) begin
			seen_array_q    <= n_seen;
			in_object_q     <= n_inobj;
			in_string_q     <= n_instr;
			escape_q        <= n_esc;
			brace_depth_q   <= n_depth;
			object_length_q <= n_len;
			overflowed_q    <= n_ovf;
			finished_q      <= n_fin;
			object_count_q  <= n_count;
		end
	end

	// Checks
	`JAOF_ASSERT_IMPL(a_good_needs_end, clk, arst_n, res_push && res.object_good, res.object_end)
	`JAOF_ASSERT_IMPL(a_escape_in_string, clk, arst_n, escape_q, in_string_q)
	`JAOF_ASSERT_IMPL(a_string_in_object, clk, arst_n, in_string_q, in_object_q)
	`JAOF_ASSERT_IMPL(a_object_depth, clk, arst_n, in_object_q, brace_depth_q != '0)
	`JAOF_ASSERT_NEXT(a_done_sticky, clk, arst_n, step && finished_q && !item.restart, finished_q)

endmodule

/* rtl/core/json_array_object_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_array_object_framer
// Frames top-level objects of a JSON array from a byte stream.
// ----------------------------------------------------------------------------
// Bytes go in through a queue-style port (push/full) and one result per byte
// comes out through a queue-style port (empty/pop). The block sustains one
// byte per clock while the result queue has room: the scan state (string,
// escape, brace depth, object length, object count) updates once per byte,
// and that register loop sets the rate. A byte goes through the command
// queue, is scanned from its head, and its result is registered into the
// result queue. The input side keeps taking bytes into a QUEUE_DEPTH-entry
// command queue while results wait to be popped. Configuration registers
// (index 0: max_object_bytes, index 1: max_objects) are always ready and
// should be written only while the block is idle; other indexes are ignored.
// ----------------------------------------------------------------------------
module json_array_object_framer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// byte input
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       data_byte,
	input  logic                             restart,
	// result output
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       byte_out,
	output logic                             keep,
	output logic [10:0]                      position,
	output logic                             object_end,
	output logic                             object_good,
	output logic                             scan_done,
	output logic [9:0]                       objects_seen,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [jaof_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [11:0]                      cfg_data
);
	import jaof_pkg::*;

	cfg_t       cfg_q;
	logic       item_valid;
	scan_item_t item;
	logic       item_pop;
	logic       res_push;
	logic       res_full;
	result_t    res;
	result_t    res_head;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_object_bytes <= MAX_OBJECT_BYTES_RST;
			cfg_q.max_objects      <= MAX_OBJECTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_OBJECT_BYTES: cfg_q.max_object_bytes <= cfg_data;
				CFG_MAX_OBJECTS:      cfg_q.max_objects      <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Front: accept and classify
	jaof_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.restart    (restart),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// Back: scan
	jaof_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_ready  (!res_full),
		.res_push   (res_push),
		.res        (res)
	);

	// Result queue
	jaof_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign byte_out     = res_head.byte_out;
	assign keep         = res_head.keep;
	assign position     = res_head.position;
	assign object_end   = res_head.object_end;
	assign object_good  = res_head.object_good;
	assign scan_done    = res_head.scan_done;
	assign objects_seen = res_head.objects_seen;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON array object framer.
// ----------------------------------------------------------------------------
// Feeds byte streams into the framer: a short hand-written sequence, then
// generated arrays of objects with nested braces, strings and escapes, mixed
// with raw noise and restarts. It runs under several register settings: zero
// and oversized length limits, zero and largest object limits, and an object
// limit written with upper data bits set. One directed object nests forty
// levels deep. A scoreboard predicts the result of every accepted byte and
// compares it field by field with what the framer returns. Both ports stall
// at random, and the result side holds off once long enough to fill the
// framer.
// ----------------------------------------------------------------------------
module tb_top;
	import jaof_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE_TICKS = 4;
	localparam int TAIL_TICKS   = 10;

	// Predicts framer results and checks them in order
	class framer_scoreboard;
		logic [11:0] obj_byte_limit;
		logic [9:0]  obj_count_limit;

		bit          seen_open_bracket;
		bit          inside_object;
		bit          inside_string;
		bit          escape_next;
		logic [10:0] nest_depth;
		logic [11:0] kept_len;
		bit          too_long;
		bit          scan_over;
		logic [9:0]  closed_count;

		result_t     expected_q[$];
		int          fail_count;

		function new();
			obj_byte_limit  = MAX_OBJECT_BYTES_RST;
			obj_count_limit = MAX_OBJECTS_RST;
			fail_count      = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			seen_open_bracket = 0;
			inside_object     = 0;
			inside_string     = 0;
			escape_next       = 0;
			nest_depth        = '0;
			kept_len          = '0;
			too_long          = 0;
			scan_over         = 0;
			closed_count      = '0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [11:0] val);
			if (idx == CFG_MAX_OBJECT_BYTES)
				obj_byte_limit = val;
			else if (idx == CFG_MAX_OBJECTS)
				obj_count_limit = val[9:0];
		endfunction

		// Advance the scan by one accepted byte and queue its result
		function void note_byte(logic [7:0] c, logic rst);
			result_t     r;
			logic [11:0] limit;
			limit = (obj_byte_limit > BUFFER_LIMIT) ? BUFFER_LIMIT : obj_byte_limit;
			if (rst)
				clear_scan();
			r = '0;
			r.byte_out = c;
			if (!scan_over) begin
				if (!seen_open_bracket) begin
					if (c == ASCII_LBRACKET)
						seen_open_bracket = 1;
				end else if (!inside_object) begin
					if (c == ASCII_LBRACE) begin
						inside_object = 1;
						inside_string = 0;
						escape_next   = 0;
						too_long      = 0;
						nest_depth    = 11'd1;
						kept_len      = 12'd1;
						r.keep        = 1'b1;
					end else if (c == ASCII_RBRACKET) begin
						scan_over = 1;
					end
				end else begin
					// store while below the limit, otherwise mark overflow
					if (kept_len < limit) begin
						r.keep     = 1'b1;
						r.position = kept_len[10:0];
						kept_len++;
					end else begin
						too_long = 1;
					end
					if (inside_string) begin
						if (escape_next)
							escape_next = 0;
						else if (c == ASCII_BSLASH)
							escape_next = 1;
						else if (c == ASCII_QUOTE)
							inside_string = 0;
					end else if (c == ASCII_QUOTE) begin
						inside_string = 1;
					end else if (c == ASCII_LBRACE) begin
						if (nest_depth < DEPTH_MAX)
							nest_depth++;
					end else if (c == ASCII_RBRACE) begin
						if (nest_depth != 0)
							nest_depth--;
						if (nest_depth == 0) begin
							inside_object = 0;
							r.object_end  = 1'b1;
							r.object_good = !too_long;
							kept_len      = '0;
							if (closed_count < COUNT_MAX)
								closed_count++;
							if (closed_count >= obj_count_limit)
								scan_over = 1;
						end
					end
				end
			end
			r.scan_done    = scan_over;
			r.objects_seen = closed_count;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				fail_count++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual byte_out %0d",
					$time, got.byte_out);
				fail_count++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("byte_out", want.byte_out, got.byte_out);
			compare_field("keep", want.keep, got.keep);
			compare_field("position", want.position, got.position);
			compare_field("object_end", want.object_end, got.object_end);
			compare_field("object_good", want.object_good, got.object_good);
			compare_field("scan_done", want.scan_done, got.scan_done);
			compare_field("objects_seen", want.objects_seen, got.objects_seen);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   push         = 1'b0;
	logic                   full;
	logic [7:0]             data_byte    = '0;
	logic                   restart      = 1'b0;
	logic                   empty;
	logic                   pop          = 1'b0;
	logic [7:0]             byte_out;
	logic                   keep;
	logic [10:0]            position;
	logic                   object_end;
	logic                   object_good;
	logic                   scan_done;
	logic [9:0]             objects_seen;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [11:0]            cfg_data     = '0;

	framer_scoreboard sb;
	logic [7:0]       doc_q[$];
	bit               tx_idle_en = 0;
	bit               rx_idle_en = 0;
	bit               no_idle    = 0;
	bit               hold_req   = 0;
	int               stall_cycles = 0;

	json_array_object_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.restart      (restart),
		.empty        (empty),
		.pop          (pop),
		.byte_out     (byte_out),
		.keep         (keep),
		.position     (position),
		.object_end   (object_end),
		.object_good  (object_good),
		.scan_done    (scan_done),
		.objects_seen (objects_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: ends the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Random byte that differs from the three given
	function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b || v == c);
		return v;
	endfunction

	// String with escapes and braces that must not count
	task automatic add_string(int n);
		doc_q.push_back(ASCII_QUOTE);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: begin
					doc_q.push_back(ASCII_BSLASH);
					doc_q.push_back(8'($urandom_range(0, 255)));
				end
				1: doc_q.push_back($urandom_range(0, 1) ? ASCII_LBRACE : ASCII_RBRACE);
				default: doc_q.push_back(pick_byte(ASCII_QUOTE, ASCII_BSLASH, ASCII_QUOTE));
			endcase
		end
		doc_q.push_back(ASCII_QUOTE);
	endtask

	task automatic add_object(int depth);
		int members;
		members = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 12 : 4);
		doc_q.push_back(ASCII_LBRACE);
		for (int i = 0; i < members; i++) begin
			case ($urandom_range(0, 3))
				0: add_string($urandom_range(0, 8));
				1: begin
					if (depth > 0)
						add_object(depth - 1);
					else
						doc_q.push_back(pick_byte(ASCII_LBRACE, ASCII_RBRACE, ASCII_QUOTE));
				end
				2: begin
					repeat ($urandom_range(1, 6))
						doc_q.push_back(pick_byte(ASCII_LBRACE, ASCII_RBRACE, ASCII_QUOTE));
				end
				default: doc_q.push_back($urandom_range(0, 1) ? ASCII_LBRACKET : ASCII_RBRACKET);
			endcase
		end
		doc_q.push_back(ASCII_RBRACE);
	endtask

	// Well-formed array with junk around and between the objects
	task automatic build_array(int n_obj);
		doc_q.delete();
		repeat ($urandom_range(0, 3))
			doc_q.push_back(pick_byte(ASCII_LBRACKET, ASCII_LBRACKET, ASCII_LBRACKET));
		doc_q.push_back(ASCII_LBRACKET);
		for (int i = 0; i < n_obj; i++) begin
			repeat ($urandom_range(0, 2))
				doc_q.push_back(pick_byte(ASCII_LBRACE, ASCII_RBRACKET, ASCII_LBRACE));
			add_object($urandom_range(0, 3));
		end
		doc_q.push_back(ASCII_RBRACKET);
		repeat ($urandom_range(0, 3))
			doc_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Raw bytes rich in structural characters
	task automatic build_noise(int n);
		logic [7:0] marks[6];
		marks = '{ASCII_LBRACKET, ASCII_RBRACKET, ASCII_LBRACE, ASCII_RBRACE,
			ASCII_QUOTE, ASCII_BSLASH};
		doc_q.delete();
		repeat (n) begin
			if ($urandom_range(0, 1))
				doc_q.push_back(marks[$urandom_range(0, 5)]);
			else
				doc_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// One input transaction, with an optional idle burst in front
	task automatic send_byte(logic [7:0] b, logic r);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		restart   <= r;
		do
			@(posedge clk);
		while (full);
		sb.note_byte(b, r);
	endtask

	task automatic send_doc(bit first_restart);
		foreach (doc_q[i])
			send_byte(doc_q[i], (i == 0) ? first_restart : ($urandom_range(0, 199) == 0));
	endtask

	task automatic run_random(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if (no_idle) begin
				tx_idle_en = 0;
				rx_idle_en = 0;
			end else begin
				tx_idle_en = $urandom_range(0, 1);
				rx_idle_en = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 6) == 0)
				build_noise($urandom_range(4, 24));
			else
				build_array($urandom_range(1, 6));
			send_doc($urandom_range(0, 9) != 0);
			sent += doc_q.size();
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Writes both registers once the framer has gone idle
	task automatic reconfigure(logic [11:0] byte_limit, logic [11:0] obj_limit);
		drain_results();
		repeat (SETTLE_TICKS)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_OBJECT_BYTES;
		cfg_data  <= byte_limit;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(CFG_MAX_OBJECT_BYTES, byte_limit);
		cfg_index <= CFG_MAX_OBJECTS;
		cfg_data  <= obj_limit;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(CFG_MAX_OBJECTS, obj_limit);
		cfg_valid <= 1'b0;
	endtask

	// Result side: pops with random idle bursts and one long hold
	initial begin : result_side
		int idle_left;
		int hold_left;
		result_t got;
		idle_left = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = '{byte_out, keep, position, object_end, object_good, scan_done,
					objects_seen};
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				pop <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				idle_left = $urandom_range(0, 5);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Byte side: directed sequence, then phases under different settings
	initial begin : byte_side
		logic [8:0] directed[$];
		sb = new();
		// {restart, byte}
		directed = '{{1'b1, 8'h00}, {1'b0, 8'hFF}, {1'b0, ASCII_LBRACE},
			{1'b0, ASCII_LBRACKET}, {1'b0, 8'h41}, {1'b0, ASCII_LBRACE},
			{1'b0, ASCII_QUOTE}, {1'b0, ASCII_BSLASH}, {1'b0, ASCII_QUOTE},
			{1'b0, ASCII_RBRACE}, {1'b0, ASCII_QUOTE}, {1'b0, ASCII_LBRACE},
			{1'b0, 8'hFF}, {1'b0, ASCII_RBRACE}, {1'b0, ASCII_RBRACE},
			{1'b0, ASCII_RBRACKET}, {1'b0, ASCII_LBRACE}, {1'b1, ASCII_LBRACKET},
			{1'b0, ASCII_LBRACE}, {1'b0, ASCII_RBRACE}, {1'b0, 8'hFF},
			{1'b0, ASCII_RBRACKET}};

		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);
		run_random(300);

		// short objects overflow often, scan stops after three objects
		reconfigure(12'd8, 12'd3);
		run_random(220);

		// zero length limit and zero object limit
		reconfigure(12'd0, 12'd0);
		run_random(120);

		reconfigure(12'd1, 12'd1);
		run_random(100);

		// limit above the buffer, largest object count
		reconfigure(12'hFFF, 12'd1023);
		// one object nested well past the random depth
		doc_q.delete();
		doc_q.push_back(ASCII_LBRACKET);
		repeat (40)
			doc_q.push_back(ASCII_LBRACE);
		repeat (40)
			doc_q.push_back(ASCII_RBRACE);
		doc_q.push_back(ASCII_RBRACKET);
		send_doc(1'b1);
		run_random(80);

		// long hold on the result side while bytes keep coming
		reconfigure(12'd2048, 12'd7);
		run_random(120);
		no_idle  = 1;
		hold_req = 1;
		run_random(180);
		no_idle  = 0;
		// sender waits for every outstanding result
		drain_results();
		run_random(80);

		// upper data bits are dropped for the object limit
		reconfigure(12'd40, 12'hC05);
		no_idle = 1;
		run_random(150);

		drain_results();
		repeat (TAIL_TICKS)
			@(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
